/* design/isnb_pkg.sv */
// ----------------------------------------------------------------------------
// isnb_pkg: shared constants and types of the image scaler
// Sizes, fixed-point widths, register indexes and command codes used by the
// scaler, its channel interfaces and its port checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isnb_pkg;

	// Image store geometry
	localparam int MAX_WIDTH   = 512;
	localparam int MAX_HEIGHT  = 512;
	localparam int OUT_MAX     = 4096;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int AREA_W      = ADDR_W + 1;

	// Field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int DIM_W      = 10;
	localparam int OUT_DIM_W  = 13;
	localparam int STEP_W     = 24;
	localparam int POS_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Fixed-point source coordinates
	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 28;
	localparam int COORD_W   = ACC_W - FRAC_BITS + 1;
	localparam int WEIGHT_W  = FRAC_BITS + 1;

	// Shared multiplier and accumulator widths
	localparam int TOP_W   = SAMPLE_W + FRAC_BITS;
	localparam int MUL_A_W = WEIGHT_W + 1;
	localparam int MUL_B_W = TOP_W + 2;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int SUM_W   = SAMPLE_W + 2 * FRAC_BITS + 2;
	localparam int RND_W   = SUM_W + 1 - 2 * FRAC_BITS;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd6;

	// Command and mode codes
	localparam logic OP_LOAD       = 1'b0;
	localparam logic OP_EMIT       = 1'b1;
	localparam logic MODE_NEAREST  = 1'b0;
	localparam logic MODE_BILINEAR = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic [ACC_W-1:0]           acc_t;
	typedef logic [POS_W-1:0]           pos_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

endpackage

`default_nettype wire

/* design/isnb_if.sv */
// ----------------------------------------------------------------------------
// isnb_if: channel interfaces of the image scaler
// Command channel, pixel result channel and register write channel, each with
// a valid/ready handshake; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface isnb_item_if;
	import isnb_pkg::*;

	logic    valid;
	logic    ready;
	logic    opcode;
	sample_t sample;

	modport source (output valid, output opcode, output sample, input ready);
	modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface isnb_pixel_if;
	import isnb_pkg::*;

	logic    valid;
	logic    ready;
	sample_t pixel;
	logic    last;

	modport source (output valid, output pixel, output last, input ready);
	modport sink   (input valid, input pixel, input last, output ready);
endinterface

interface isnb_cfg_if;
	import isnb_pkg::*;

	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/image_scaler_nearest_bilinear_unit.sv */
// ----------------------------------------------------------------------------
// image_scaler_nearest_bilinear_unit: nearest / bilinear image scaler
// A load command writes the next sample of the source image in raster order.
// An emit command returns the next pixel of the scaled image in raster order:
// nearest neighbor goes through accept, row offset multiply, memory read and
// result register, and a pixel that falls outside the image skips the read.
// The bilinear path is paced by the single-port image memory (four reads)
// and by the one shared 18x34 multiplier, which forms the row offset and then
// six products: two horizontal blends of two samples each, then the vertical
// blend of the two rows. The block is not ready while an emit is in progress,
// and in the cycle after each register write while the image area is
// recomputed. A finished pixel waits in an output register, so loads go on
// while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module image_scaler_nearest_bilinear_unit (
	input  wire            clk,
	input  wire            arst_n,
	isnb_cfg_if.sink       cfg,
	isnb_item_if.sink      item,
	isnb_pixel_if.source   result
);
	import isnb_pkg::*;

	// Sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_BASE = 4'd1;
	localparam logic [3:0] ST_RD00 = 4'd2;
	localparam logic [3:0] ST_RD10 = 4'd3;
	localparam logic [3:0] ST_RD01 = 4'd4;
	localparam logic [3:0] ST_RD11 = 4'd5;
	localparam logic [3:0] ST_M4   = 4'd6;
	localparam logic [3:0] ST_M5   = 4'd7;
	localparam logic [3:0] ST_M6   = 4'd8;
	localparam logic [3:0] ST_SUM  = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;
	localparam logic [3:0] ST_NFIN = 4'd11;
	localparam logic [3:0] ST_ZERO = 4'd12;

	localparam logic [ACC_W:0]      HALF     = (ACC_W+1)'(1) << (FRAC_BITS - 1);
	localparam logic [WEIGHT_W-1:0] ONE      = WEIGHT_W'(1) << FRAC_BITS;
	localparam logic [SUM_W:0]      RND_BIAS = (SUM_W+1)'(1) << (2 * FRAC_BITS - 1);
	localparam logic signed [RND_W-1:0] PIX_MAX = RND_W'((2 ** (SAMPLE_W - 1)) - 1);
	localparam logic signed [RND_W-1:0] PIX_MIN = -RND_W'(2 ** (SAMPLE_W - 1));

	// Configuration registers
	logic [DIM_W-1:0]     in_width_q, in_height_q;
	logic [OUT_DIM_W-1:0] out_width_q, out_height_q;
	logic [STEP_W-1:0]    step_x_q, step_y_q;
	logic                 interp_mode_q;
	logic                 settle_q;
	logic [AREA_W-1:0]    area_q;

	// Position state
	addr_t load_addr_q;
	pos_t  col_q, row_q;
	acc_t  acc_x_q, acc_y_q;

	// Per-pixel work registers
	logic [3:0]            state_q;
	acc_t                  cx_q, cy_q;
	logic                  last_q;
	logic [DIM_W-1:0]      x0_q, x1_q;
	logic                  yadv_q;
	logic [FRAC_BITS-1:0]  fx_q, fy_q;
	addr_t                 base_q;
	sample_t               rd_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [SUM_W-1:0]   h_q;
	logic signed [TOP_W-1:0]   top_q;

	// Result register
	logic    out_valid_q;
	sample_t out_pixel_q;
	logic    out_last_q;

	// Image store
	sample_t image_mem_q [STORE_DEPTH];

	// Clamped sizes
	logic [DIM_W-1:0]     w_dim, h_dim;
	logic [OUT_DIM_W-1:0] ow_dim, oh_dim;

	always_comb begin
		if (in_width_q == '0)
			w_dim = DIM_W'(1);
		else if (in_width_q > DIM_W'(MAX_WIDTH))
			w_dim = DIM_W'(MAX_WIDTH);
		else
			w_dim = in_width_q;
		if (in_height_q == '0)
			h_dim = DIM_W'(1);
		else if (in_height_q > DIM_W'(MAX_HEIGHT))
			h_dim = DIM_W'(MAX_HEIGHT);
		else
			h_dim = in_height_q;
		if (out_width_q == '0)
			ow_dim = OUT_DIM_W'(1);
		else if (out_width_q > OUT_DIM_W'(OUT_MAX))
			ow_dim = OUT_DIM_W'(OUT_MAX);
		else
			ow_dim = out_width_q;
		if (out_height_q == '0)
			oh_dim = OUT_DIM_W'(1);
		else if (out_height_q > OUT_DIM_W'(OUT_MAX))
			oh_dim = OUT_DIM_W'(OUT_MAX);
		else
			oh_dim = out_height_q;
	end

	// Handshakes
	logic item_acc, load_acc, emit_acc, cfg_acc, out_free;

	assign cfg.ready     = 1'b1;
	assign item.ready    = (state_q == ST_IDLE) && !settle_q;
	assign cfg_acc       = cfg.valid && cfg.ready;
	assign item_acc      = item.valid && item.ready;
	assign load_acc      = item_acc && (item.opcode == OP_LOAD);
	assign emit_acc      = item_acc && (item.opcode == OP_EMIT);
	assign out_free      = !out_valid_q || result.ready;
	assign result.valid  = out_valid_q;
	assign result.pixel  = out_pixel_q;
	assign result.last   = out_last_q;

	// Write configuration registers; hold off items in the next cycle for the area
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q    <= DIM_W'(512);
			in_height_q   <= DIM_W'(512);
			out_width_q   <= OUT_DIM_W'(512);
			out_height_q  <= OUT_DIM_W'(512);
			step_x_q      <= STEP_W'(65536);
			step_y_q      <= STEP_W'(65536);
			interp_mode_q <= MODE_NEAREST;
			settle_q      <= 1'b0;
			area_q        <= AREA_W'(512 * 512);
		end else begin
			settle_q <= cfg_acc;
			area_q   <= AREA_W'(w_dim * h_dim);
			if (cfg_acc) begin
				unique case (cfg.index)
					REG_IN_WIDTH:    in_width_q    <= cfg.data[DIM_W-1:0];
					REG_IN_HEIGHT:   in_height_q   <= cfg.data[DIM_W-1:0];
					REG_OUT_WIDTH:   out_width_q   <= cfg.data[OUT_DIM_W-1:0];
					REG_OUT_HEIGHT:  out_height_q  <= cfg.data[OUT_DIM_W-1:0];
					REG_STEP_X:      step_x_q      <= cfg.data[STEP_W-1:0];
					REG_STEP_Y:      step_y_q      <= cfg.data[STEP_W-1:0];
					REG_INTERP_MODE: interp_mode_q <= cfg.data[0];
					default: ;
				endcase
			end
		end
	end

	// Next positions and saturating source coordinates
	logic [ACC_W:0] acc_x_sum, acc_y_sum;
	logic           col_end, row_end;

	assign acc_x_sum = {1'b0, acc_x_q} + (ACC_W+1)'(step_x_q);
	assign acc_y_sum = {1'b0, acc_y_q} + (ACC_W+1)'(step_y_q);
	assign col_end   = ({1'b0, col_q} + OUT_DIM_W'(1)) >= ow_dim;
	assign row_end   = ({1'b0, row_q} + OUT_DIM_W'(1)) >= oh_dim;

	// Advance load address and output position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_addr_q <= '0;
			col_q       <= '0;
			row_q       <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
		end else begin
			if (load_acc) begin
				if (({1'b0, load_addr_q} + AREA_W'(1)) >= area_q)
					load_addr_q <= '0;
				else
					load_addr_q <= load_addr_q + ADDR_W'(1);
			end
			if (emit_acc) begin
				if (col_end) begin
					col_q   <= '0;
					acc_x_q <= '0;
					if (row_end) begin
						row_q   <= '0;
						acc_y_q <= '0;
					end else begin
						row_q   <= row_q + POS_W'(1);
						acc_y_q <= acc_y_sum[ACC_W] ? '1 : acc_y_sum[ACC_W-1:0];
					end
				end else begin
					col_q   <= col_q + POS_W'(1);
					acc_x_q <= acc_x_sum[ACC_W] ? '1 : acc_x_sum[ACC_W-1:0];
				end
			end
		end
	end

	// Source index: rounded for nearest, floor for bilinear
	logic [ACC_W:0]   cx_round, cy_round;
	logic [COORD_W-1:0] xi, yi;
	logic [COORD_W:0]   xi_inc, yi_inc;
	logic             outside;

	assign cx_round = {1'b0, cx_q} + HALF;
	assign cy_round = {1'b0, cy_q} + HALF;
	assign xi = (interp_mode_q == MODE_BILINEAR) ?
		{1'b0, cx_q[ACC_W-1:FRAC_BITS]} : cx_round[ACC_W:FRAC_BITS];
	assign yi = (interp_mode_q == MODE_BILINEAR) ?
		{1'b0, cy_q[ACC_W-1:FRAC_BITS]} : cy_round[ACC_W:FRAC_BITS];
	assign xi_inc  = {1'b0, xi} + (COORD_W+1)'(1);
	assign yi_inc  = {1'b0, yi} + (COORD_W+1)'(1);
	assign outside = (xi >= COORD_W'(w_dim)) || (yi >= COORD_W'(h_dim));

	// Blend weights
	logic [WEIGHT_W-1:0] wx0, wx1, wy0, wy1;

	assign wx0 = ONE - WEIGHT_W'(fx_q);
	assign wx1 = WEIGHT_W'(fx_q);
	assign wy0 = ONE - WEIGHT_W'(fy_q);
	assign wy1 = WEIGHT_W'(fy_q);

	// Shared multiplier operand select
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_A_W-1:0] rd_ext;

	assign rd_ext = {{(MUL_A_W-SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_BASE: begin
				mul_a = {{(MUL_A_W-DIM_W){1'b0}}, w_dim};
				mul_b = {{(MUL_B_W-COORD_W){1'b0}}, yi};
			end
			ST_RD10, ST_RD11: begin
				mul_a = rd_ext;
				mul_b = {{(MUL_B_W-WEIGHT_W){1'b0}}, wx0};
			end
			ST_RD01, ST_M4: begin
				mul_a = rd_ext;
				mul_b = {{(MUL_B_W-WEIGHT_W){1'b0}}, wx1};
			end
			ST_M5: begin
				mul_a = {1'b0, wy0};
				mul_b = {{(MUL_B_W-TOP_W){top_q[TOP_W-1]}}, top_q};
			end
			ST_M6: begin
				mul_a = {1'b0, wy1};
				mul_b = {{(MUL_B_W-TOP_W){h_q[TOP_W-1]}}, h_q[TOP_W-1:0]};
			end
			default: ;
		endcase
	end

	// Image memory address select
	addr_t row1_base, rd_addr;
	logic  rd_en;

	assign row1_base = base_q + (yadv_q ? ADDR_W'(w_dim) : ADDR_W'(0));

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = '0;
		unique case (state_q)
			ST_RD00: rd_addr = prod_q[ADDR_W-1:0] + ADDR_W'(x0_q);
			ST_RD10: rd_addr = base_q + ADDR_W'(x1_q);
			ST_RD01: rd_addr = row1_base + ADDR_W'(x0_q);
			ST_RD11: rd_addr = row1_base + ADDR_W'(x1_q);
			default: rd_en = 1'b0;
		endcase
	end

	// Write loaded samples, read neighbors
	always_ff @(posedge clk) begin
		if (load_acc)
			image_mem_q[load_addr_q] <= item.sample;
		if (rd_en)
			rd_q <= image_mem_q[rd_addr];
	end

	// Round half up and saturate the blended sum
	logic [SUM_W:0]          rnd_sum;
	logic signed [RND_W-1:0] rnd_int;
	sample_t                 blend_pix, fin_pix;

	assign rnd_sum = {h_q[SUM_W-1], h_q} + RND_BIAS;
	assign rnd_int = rnd_sum[SUM_W:2*FRAC_BITS];

	always_comb begin
		if (rnd_int > PIX_MAX)
			blend_pix = sample_t'(PIX_MAX);
		else if (rnd_int < PIX_MIN)
			blend_pix = sample_t'(PIX_MIN);
		else
			blend_pix = rnd_int[SAMPLE_W-1:0];
		unique case (state_q)
			ST_FIN:  fin_pix = blend_pix;
			ST_NFIN: fin_pix = rd_q;
			default: fin_pix = '0;
		endcase
	end

	// Multiply, accumulate and latch per-pixel operands
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (emit_acc) begin
			cx_q   <= acc_x_q;
			cy_q   <= acc_y_q;
			last_q <= col_end && row_end;
		end
		unique case (state_q)
			ST_BASE: begin
				x0_q   <= xi[DIM_W-1:0];
				x1_q   <= (xi_inc < (COORD_W+1)'(w_dim)) ?
					xi_inc[DIM_W-1:0] : xi[DIM_W-1:0];
				yadv_q <= yi_inc < (COORD_W+1)'(h_dim);
				fx_q   <= cx_q[FRAC_BITS-1:0];
				fy_q   <= cy_q[FRAC_BITS-1:0];
			end
			ST_RD00: base_q <= prod_q[ADDR_W-1:0];
			ST_RD01, ST_M6: h_q <= prod_q[SUM_W-1:0];
			ST_RD11, ST_M5, ST_SUM: h_q <= h_q + prod_q[SUM_W-1:0];
			ST_M4: begin
				top_q <= h_q[TOP_W-1:0];
				h_q   <= prod_q[SUM_W-1:0];
			end
			default: ;
		endcase
	end

	// Sequence one emit through the shared multiplier and the memory port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (emit_acc) state_q <= ST_BASE;
				ST_BASE: state_q <= outside ? ST_ZERO : ST_RD00;
				ST_RD00: state_q <= (interp_mode_q == MODE_BILINEAR) ? ST_RD10 : ST_NFIN;
				ST_RD10: state_q <= ST_RD01;
				ST_RD01: state_q <= ST_RD11;
				ST_RD11: state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5:   state_q <= ST_M6;
				ST_M6:   state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_FIN;
				ST_FIN, ST_NFIN, ST_ZERO: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result beat until taken
	logic fin_state;

	assign fin_state = (state_q == ST_FIN) || (state_q == ST_NFIN) || (state_q == ST_ZERO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_state && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_state && out_free) begin
			out_pixel_q <= fin_pix;
			out_last_q  <= last_q;
		end
	end

endmodule

`default_nettype wire

/* design/isnb_checker.sv */
// ----------------------------------------------------------------------------
// isnb_checker: port-level checks of the image scaler
// Watches the command, result and register channels of the top level and is
// bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isnb_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    in_valid,
	input wire                    in_ready,
	input wire                    in_opcode,
	input wire                    out_valid,
	input wire                    out_ready,
	input wire isnb_pkg::sample_t out_pixel,
	input wire                    out_last,
	input wire                    cfg_valid,
	input wire                    cfg_ready
);
	import isnb_pkg::*;

	// A register write holds off the command channel in the following cycle
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("command ready right after a register write");

	// An emit keeps the command channel closed while it is in progress
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode == OP_EMIT) |=> !in_ready)
		else $error("command ready right after an emit");

	// A result only appears when an emit was in progress
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result beat without an emit in progress");

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_last))
		else $error("stalled result beat changed");

endmodule

bind image_scaler_nearest_bilinear_unit isnb_checker u_isnb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_opcode (item.opcode),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_pixel (result.pixel),
	.out_last  (result.last),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

`default_nettype wire
